/* design/tgarle_pkg.sv */
// Shared types, constants and tables for the TGA run-length decoder.
`timescale 1ns / 1ps

package tgarle_pkg;

    // Byte-total counter width and the width of the reported total
    localparam int COUNT_WIDTH = 24;
    localparam int TOTAL_W     = 24;
    localparam int LIMIT_W     = 24;
    localparam int CFG_W       = 24;

    // Depth of the queue between parser and converter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stored pixel sizes
    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;
    localparam logic [1:0] MODE_24 = 2'd2;
    localparam logic [1:0] MODE_32 = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_MODE    = 2'd0;
    localparam logic [1:0] CFG_ALPHA_PRESENT = 2'd1;
    localparam logic [1:0] CFG_OUT_LIMIT     = 2'd2;

    // Header byte fields
    localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;

    // floor(v * 255 / 31) for a 5-bit colour field
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic               pixel_valid;
        logic [7:0]         out_b0;
        logic [7:0]         out_b1;
        logic [7:0]         out_b2;
        logic [7:0]         out_b3;
        logic [7:0]         repeat_count;
        logic               stream_end;
        logic               overflow;
        logic [TOTAL_W-1:0] total_bytes;
    } t_out;

    // Event from parser to converter: a finished pixel and/or end of stream
    typedef struct packed {
        logic        have_pixel;
        logic [31:0] pix;
        logic [7:0]  rep;
        logic        last;
    } t_evt;

endpackage

/* design/tgarle_front.sv */
// Packet parser: takes stream bytes, gathers pixels and emits events.
`timescale 1ns / 1ps

module tgarle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_pixel_mode,
    input  logic               i_in_valid,
    input  tgarle_pkg::t_in    i_in_data,
    output logic               o_in_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output tgarle_pkg::t_evt   o_evt
);
    import tgarle_pkg::*;

    logic        r_expect_hdr, n_expect_hdr;
    logic        r_run, n_run;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_buf, n_buf;

    logic        w_accept;
    logic [31:0] w_pix;
    logic [1:0]  w_idx_inc;
    logic        w_done;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // Drop the new byte into its lane of the gathered pixel
    always_comb begin
        w_pix = r_buf;
        case (r_idx)
            2'd0:    w_pix[7:0]   = i_in_data.data_byte;
            2'd1:    w_pix[15:8]  = i_in_data.data_byte;
            2'd2:    w_pix[23:16] = i_in_data.data_byte;
            default: w_pix[31:24] = i_in_data.data_byte;
        endcase
    end

    assign w_idx_inc = r_idx + 2'd1;
    assign w_done    = !r_expect_hdr &&
                       ((w_idx_inc == 2'd0) ||
                        ({1'b0, w_idx_inc} >= ({1'b0, i_pixel_mode} + 3'd1)));

    always_comb begin
        n_expect_hdr = r_expect_hdr;
        n_run        = r_run;
        n_left       = r_left;
        n_idx        = r_idx;
        n_buf        = r_buf;
        o_push       = 1'b0;
        o_evt        = '0;
        if (w_accept) begin
            if (r_expect_hdr) begin
                n_run        = (i_in_data.data_byte & HDR_RUN_MASK) != 8'd0;
                n_left       = (i_in_data.data_byte & HDR_COUNT_MASK) + 8'd1;
                n_idx        = 2'd0;
                n_buf        = '0;
                n_expect_hdr = 1'b0;
            end else if (w_done) begin
                o_push         = 1'b1;
                o_evt.have_pixel = 1'b1;
                o_evt.pix      = w_pix;
                o_evt.rep      = r_run ? r_left : 8'd1;
                n_idx          = 2'd0;
                n_buf          = '0;
                if (r_run || r_left <= 8'd1) begin
                    n_left       = 8'd0;
                    n_expect_hdr = 1'b1;
                end else begin
                    n_left = r_left - 8'd1;
                end
            end else begin
                n_idx = w_idx_inc;
                n_buf = w_pix;
            end
            // End of stream: report it and drop any unfinished packet
            if (i_in_data.last_byte) begin
                o_push       = 1'b1;
                o_evt.last   = 1'b1;
                n_expect_hdr = 1'b1;
                n_run        = 1'b0;
                n_left       = 8'd0;
                n_idx        = 2'd0;
                n_buf        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_run        <= 1'b0;
            r_left       <= 8'd0;
            r_idx        <= 2'd0;
            r_buf        <= '0;
        end else begin
            r_expect_hdr <= n_expect_hdr;
            r_run        <= n_run;
            r_left       <= n_left;
            r_idx        <= n_idx;
            r_buf        <= n_buf;
        end
    end

endmodule

/* design/tgarle_fifo.sv */
// Short event queue between the parser and the pixel converter.
`timescale 1ns / 1ps

module tgarle_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tgarle_pkg::t_evt i_evt,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nonempty,
    output tgarle_pkg::t_evt o_evt
);
    import tgarle_pkg::*;

    t_evt              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_evt      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != QCNT_W'(QUEUE_DEPTH))
        else $error("event queue written while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("event queue read while empty");
`endif

endmodule

/* design/tgarle_back.sv */
// Pixel converter: expands pixels, keeps the byte total, holds the result.
`timescale 1ns / 1ps

module tgarle_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_pixel_mode,
    input  logic                            i_alpha_present,
    input  logic [tgarle_pkg::LIMIT_W-1:0]  i_out_limit,
    input  logic                            i_q_nonempty,
    input  tgarle_pkg::t_evt                i_evt,
    output logic                            o_pop,
    output logic                            o_out_valid,
    output tgarle_pkg::t_out                o_out_data,
    input  logic                            i_out_stall
);
    import tgarle_pkg::*;

    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic                   r_out_valid;
    t_out                   r_out, n_out;

    logic [9:0]             w_rep_x;
    logic [9:0]             w_add;
    logic [COUNT_WIDTH:0]   w_sum;
    logic [32:0]            w_total_x;

    assign o_pop = i_q_nonempty && (!r_out_valid || !i_out_stall);

    // Output bytes for this pixel: rep times the converted pixel size
    assign w_rep_x = {2'b00, i_evt.rep};
    always_comb begin
        unique case (i_pixel_mode)
            MODE_8:  w_add = w_rep_x;
            MODE_32: w_add = w_rep_x << 2;
            default: w_add = w_rep_x + (w_rep_x << 1);
        endcase
        if (!i_evt.have_pixel) begin
            w_add = '0;
        end
    end

    // Saturate the running total
    assign w_sum     = {1'b0, r_total} + (COUNT_WIDTH + 1)'(w_add);
    assign n_total   = w_sum[COUNT_WIDTH] ? '1 : w_sum[COUNT_WIDTH-1:0];
    assign w_total_x = 33'(n_total);

    always_comb begin
        n_out              = '0;
        n_out.pixel_valid  = i_evt.have_pixel;
        n_out.stream_end   = i_evt.last;
        n_out.overflow     = i_evt.last && (w_total_x > 33'(i_out_limit));
        n_out.total_bytes  = (w_total_x > 33'(24'hFFFFFF)) ? 24'hFFFFFF : w_total_x[23:0];
        if (i_evt.have_pixel) begin
            n_out.repeat_count = i_evt.rep;
            unique case (i_pixel_mode)
                MODE_8: begin
                    n_out.out_b0 = i_evt.pix[7:0];
                end
                MODE_16: begin
                    n_out.out_b0 = EXPAND5[i_evt.pix[14:10]];
                    n_out.out_b1 = EXPAND5[i_evt.pix[9:5]];
                    n_out.out_b2 = EXPAND5[i_evt.pix[4:0]];
                end
                default: begin
                    n_out.out_b0 = i_evt.pix[23:16];
                    n_out.out_b1 = i_evt.pix[15:8];
                    n_out.out_b2 = i_evt.pix[7:0];
                    if (i_pixel_mode == MODE_32) begin
                        n_out.out_b3 = i_alpha_present ? i_evt.pix[31:24] : ALPHA_OPAQUE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_total     <= i_evt.last ? '0 : n_total;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.pixel_valid |-> r_out.stream_end)
        else $error("pixel-less result outside stream end");
    a_overflow_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> r_out.stream_end)
        else $error("overflow flagged before stream end");
    a_total_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_evt.last |=> r_total == '0)
        else $error("byte total not cleared after stream end");
`endif

endmodule

/* design/tga_rle_decoder.sv */
// Top level of the TGA run-length decoder: config registers and the three parts.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: one compressed stream word (data_byte, last_byte) per
//   accepted handshake, i_in_valid high and o_in_stall low at a rising edge.
//   Output channel: one result word per decoded pixel, or per last_byte
//   word ending no pixel; taken when o_out_valid is high and i_out_stall low.
//   Config port: write pixel_mode, alpha_present and out_limit through
//   i_cfg_we/i_cfg_index/i_cfg_data, only while no word is in flight.
//   A word that completes a result passes from the parser into the event
//   queue, then through the converter into the output register.
//   Throughput: one word per cycle while the event queue is not full;
//   a header or partial-pixel word yields no result.
//   Stall: when the receiver stalls, the output register holds its word and
//   the two-entry event queue fills; o_in_stall rises once the queue is full.
//   Reset: synchronous, active low; clears the parser (awaiting a header),
//   the queue, the byte total and restores the config registers to
//   24-bit mode, no alpha, limit 0xFFFFFF. No clearing pass is needed.
//
module tga_rle_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  tgarle_pkg::t_in                i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output tgarle_pkg::t_out               o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [tgarle_pkg::CFG_W-1:0]   i_cfg_data
);
    import tgarle_pkg::*;

    // Configuration registers
    logic [1:0]         r_pixel_mode;
    logic               r_alpha_present;
    logic [LIMIT_W-1:0] r_out_limit;

    // Parser to queue
    logic w_push;
    t_evt w_push_evt;
    logic w_q_full;

    // Queue to converter
    logic w_pop;
    logic w_q_nonempty;
    t_evt w_pop_evt;

    // Latch register writes; an index beyond the list writes nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode    <= MODE_24;
            r_alpha_present <= 1'b0;
            r_out_limit     <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXEL_MODE:    r_pixel_mode    <= i_cfg_data[1:0];
                CFG_ALPHA_PRESENT: r_alpha_present <= i_cfg_data[0];
                CFG_OUT_LIMIT:     r_out_limit     <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: classify header and pixel words, gather pixel bytes
    tgarle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel_mode (r_pixel_mode),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_evt        (w_push_evt)
    );

    // Decouple parser and converter so each side stalls on its own
    tgarle_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_evt      (w_push_evt),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_nonempty (w_q_nonempty),
        .o_evt      (w_pop_evt)
    );

    // Back: convert pixels, advance the byte total, hold the result word
    tgarle_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pixel_mode    (r_pixel_mode),
        .i_alpha_present (r_alpha_present),
        .i_out_limit     (r_out_limit),
        .i_q_nonempty    (w_q_nonempty),
        .i_evt           (w_pop_evt),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data),
        .i_out_stall     (i_out_stall)
    );

endmodule

/* tb/tga_rle_decoder_test.sv */
// Self-checking testbench for the TGA run-length decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tga_rle_decoder_test;
    import tgarle_pkg::*;

    localparam longint unsigned TOTAL_CAP = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [TOTAL_W-1:0] SHOWN_MAX = '1;
    localparam int RANDOM_BYTES  = 1350;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_in              i_in_data   = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out             o_out_data;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [1:0]       i_cfg_index = CFG_PIXEL_MODE;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    // Shadow of the configuration registers
    logic [1:0]         cur_mode;
    logic               cur_alpha;
    logic [LIMIT_W-1:0] cur_limit;

    // Shadow of the packet parser
    logic            await_header;
    logic            run_pkt;
    logic [7:0]      px_left;
    logic [1:0]      gathered;
    logic [31:0]     pix_buf;
    longint unsigned byte_total;

    t_out pending_pixels[$];
    int   fault_count    = 0;
    int   bytes_sent     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    tga_rle_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("tga_rle_decoder_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] scale5(input logic [4:0] v);
        return 8'((int'(v) * 255) / 31);
    endfunction

    function automatic int out_bytes(input logic [1:0] mode);
        if (mode == MODE_8)
            return 1;
        if (mode == MODE_32)
            return 4;
        return 3;
    endfunction

    function automatic void clear_parser();
        await_header = 1'b1;
        run_pkt      = 1'b0;
        px_left      = '0;
        gathered     = '0;
        pix_buf      = '0;
        byte_total   = 0;
    endfunction

    // Advance the shadow parser by one accepted word; queue the result it causes
    function automatic void decode_stream_byte(input logic [7:0] b, input logic last);
        t_out r;
        logic have;
        logic [7:0] rep;
        r    = '0;
        have = 1'b0;
        rep  = '0;
        if (await_header) begin
            run_pkt      = (b & HDR_RUN_MASK) != 0;
            px_left      = (b & HDR_COUNT_MASK) + 8'd1;
            gathered     = '0;
            pix_buf      = '0;
            await_header = 1'b0;
        end else begin
            pix_buf  = pix_buf | (32'(b) << (8 * int'(gathered)));
            gathered = gathered + 2'd1;
            // a pixel completes once the gathered count reaches the current mode's size
            if (gathered == 2'd0 || int'(gathered) >= int'(cur_mode) + 1) begin
                have = 1'b1;
                case (cur_mode)
                    MODE_8: begin
                        r.out_b0 = pix_buf[7:0];
                    end
                    MODE_16: begin
                        r.out_b0 = scale5(pix_buf[14:10]);
                        r.out_b1 = scale5(pix_buf[9:5]);
                        r.out_b2 = scale5(pix_buf[4:0]);
                    end
                    default: begin
                        r.out_b0 = pix_buf[23:16];
                        r.out_b1 = pix_buf[15:8];
                        r.out_b2 = pix_buf[7:0];
                        if (cur_mode == MODE_32)
                            r.out_b3 = cur_alpha ? pix_buf[31:24] : ALPHA_OPAQUE;
                    end
                endcase
                rep = run_pkt ? px_left : 8'd1;
                byte_total += longint'(rep) * out_bytes(cur_mode);
                if (byte_total > TOTAL_CAP)
                    byte_total = TOTAL_CAP;
                gathered = '0;
                pix_buf  = '0;
                if (run_pkt || px_left <= 8'd1) begin
                    px_left      = '0;
                    await_header = 1'b1;
                end else begin
                    px_left = px_left - 8'd1;
                end
            end
        end
        if (!have && !last)
            return;
        r.pixel_valid  = have;
        r.repeat_count = rep;
        r.stream_end   = last;
        r.overflow     = last && (byte_total > longint'(cur_limit));
        r.total_bytes  = (byte_total > longint'(SHOWN_MAX)) ? SHOWN_MAX
                                                             : byte_total[TOTAL_W-1:0];
        pending_pixels.push_back(r);
        if (last)
            clear_parser();
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    function automatic void note_fault(input string what, input t_out want, input t_out got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t %s: want pv=%0d b=%h.%h.%h.%h rep=%0d end=%0d ovf=%0d tot=%0d",
                     $time, what, want.pixel_valid, want.out_b0, want.out_b1, want.out_b2,
                     want.out_b3, want.repeat_count, want.stream_end, want.overflow,
                     want.total_bytes,
                     "\n    got pv=%0d b=%h.%h.%h.%h rep=%0d end=%0d ovf=%0d tot=%0d",
                     got.pixel_valid, got.out_b0, got.out_b1, got.out_b2, got.out_b3,
                     got.repeat_count, got.stream_end, got.overflow, got.total_bytes);
    endfunction

    function automatic void check_pixel(input t_out got);
        t_out want;
        if (pending_pixels.size() == 0) begin
            note_fault("unexpected result", '0, got);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel_valid  !== want.pixel_valid  || got.out_b0     !== want.out_b0 ||
            got.out_b1       !== want.out_b1       || got.out_b2     !== want.out_b2 ||
            got.out_b3       !== want.out_b3       || got.repeat_count !== want.repeat_count ||
            got.stream_end   !== want.stream_end   || got.overflow   !== want.overflow ||
            got.total_bytes  !== want.total_bytes)
            note_fault("result mismatch", want, got);
    endfunction

    // Sample with the stall value in force at this edge, then pick the next one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_pixel(o_out_data);
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one word, idling first at random; return at the edge that takes it
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {b, last};
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        bytes_sent++;
        decode_stream_byte(b, last);
    endtask

    // Send n bytes, lowest byte first; flag the final one when ends is set
    task automatic send_bytes(input logic [63:0] seq, input int n, input bit ends);
        for (int k = 0; k < n; k++)
            send_word(seq[8*k +: 8], ends && k == n - 1);
    endtask

    // Drop valid, wait for every queued result, then let the pipeline settle if settle is set
    task automatic drain_results(input bit settle);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PIXEL_MODE:    cur_mode  = val[1:0];
            CFG_ALPHA_PRESENT: cur_alpha = val[0];
            default:           cur_limit = val[LIMIT_W-1:0];
        endcase
    endtask

    task automatic set_format(input logic [1:0] mode, input logic alpha,
                              input logic [LIMIT_W-1:0] limit);
        write_reg(CFG_PIXEL_MODE, CFG_W'(mode));
        write_reg(CFG_ALPHA_PRESENT, CFG_W'(alpha));
        write_reg(CFG_OUT_LIMIT, CFG_W'(limit));
    endtask

    task automatic pick_random_format();
        logic [LIMIT_W-1:0] limit;
        case ($urandom_range(3))
            0:       limit = '0;
            1:       limit = '1;
            2:       limit = LIMIT_W'($urandom_range(1500));
            default: limit = LIMIT_W'($urandom);
        endcase
        set_format(2'($urandom_range(3)), 1'($urandom_range(1)), limit);
    endtask

    function automatic int pick_count();
        case ($urandom_range(19))
            0:       return 128;
            1, 2:    return $urandom_range(1, 128);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Header then the pixel bytes that a well-formed packet carries
    task automatic send_packet(input bit is_run, input int cnt, input bit ends);
        int n_bytes;
        n_bytes = (is_run ? 1 : cnt) * (int'(cur_mode) + 1);
        send_word({is_run, 7'(cnt - 1)}, 1'b0);
        for (int k = 0; k < n_bytes; k++)
            send_word(8'($urandom), ends && k == n_bytes - 1);
    endtask

    // Stream that ends before its packet does: the header alone or part of the data
    task automatic send_cut_packet();
        bit is_run;
        int cnt;
        int kept;
        is_run = 1'($urandom_range(1));
        cnt    = pick_count();
        kept   = $urandom_range(0, (is_run ? 1 : cnt) * (int'(cur_mode) + 1) - 1);
        send_word({is_run, 7'(cnt - 1)}, kept == 0);
        for (int k = 0; k < kept; k++)
            send_word(8'($urandom), k == kept - 1);
    endtask

    task automatic send_random_stream();
        int  n_pk;
        bit  ends;
        n_pk = $urandom_range(1, 5);
        for (int k = 0; k < n_pk; k++) begin
            ends = (k == n_pk - 1);
            if (ends && $urandom_range(9) == 0)
                send_cut_packet();
            else
                send_packet(1'($urandom_range(1)), pick_count(), ends);
            // hold the sender now and then until the output has caught up
            if (!ends && $urandom_range(29) == 0)
                drain_results(1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset format is 24-bit: a run of two, byte 0 and byte 2 swapped
    task automatic test_default_format();
        send_bytes(64'h5AFF0081, 4, 1'b1);
        drain_results(1'b1);
    endtask

    task automatic test_each_mode();
        // 8-bit: raw pair 00/FF, then a run of 128
        set_format(MODE_8, 1'b0, '1);
        send_bytes(64'hA5FFFF0001, 5, 1'b1);
        drain_results(1'b1);
        // 15/16-bit: words FFFF and 7C1F
        write_reg(CFG_PIXEL_MODE, CFG_W'(MODE_16));
        send_bytes(64'h7C1FFFFF01, 5, 1'b1);
        drain_results(1'b1);
        // 32-bit keeping stored alpha; total equals the limit, so no overflow
        set_format(MODE_32, 1'b1, 24'd4);
        send_bytes(64'h4433221100, 5, 1'b1);
        drain_results(1'b1);
    endtask

    task automatic test_stream_end_cases();
        set_format(MODE_24, 1'b0, 24'd1);
        // last word is a header: result carries no pixel
        send_word(8'h85, 1'b1);
        // raw pixel cut short: dropped, the end result still comes
        send_bytes(64'h221103, 3, 1'b1);
        // run of two 3-byte pixels exceeds a limit of one byte
        send_bytes(64'h33221181, 4, 1'b1);
        drain_results(1'b1);
    endtask

    // Two bytes of a 32-bit pixel, then switch to 16-bit: the third byte ends it
    task automatic test_mode_change_mid_pixel();
        set_format(MODE_32, 1'b0, '1);
        send_bytes(64'h221101, 3, 1'b0);
        drain_results(1'b1);
        write_reg(CFG_PIXEL_MODE, CFG_W'(MODE_16));
        send_bytes(64'h800033, 3, 1'b1);
        drain_results(1'b1);
    endtask

    // Twenty 32-bit runs of 128 build a total of 10240 bytes, past a limit of 10000
    task automatic test_long_runs();
        int n_pk;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_format(MODE_32, 1'b0, 24'd10000);
        n_pk = 20;
        for (int k = 0; k < n_pk; k++) begin
            send_word(8'hFF, 1'b0);
            send_bytes(64'($urandom), 4, k == n_pk - 1);
        end
        drain_results(1'b1);
    endtask

    task automatic run_random_phase(input int idle, input int stall, input int quota);
        int start;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        pick_random_format();
        start = bytes_sent;
        while (bytes_sent - start < quota) begin
            send_random_stream();
            if ($urandom_range(3) == 0) begin
                drain_results(1'b1);
                pick_random_format();
            end
        end
        drain_results(1'b1);
    endtask

    task automatic test_random_streams();
        run_random_phase(0, 0, RANDOM_BYTES / 4);
        run_random_phase(77, 0, RANDOM_BYTES / 4);
        run_random_phase(0, 77, RANDOM_BYTES / 4);
        run_random_phase(19, 19, RANDOM_BYTES / 4);
    endtask

    initial begin
        cur_mode  = MODE_24;
        cur_alpha = 1'b0;
        cur_limit = '1;
        clear_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_format();
        test_each_mode();
        test_stream_end_cases();
        test_mode_change_mid_pixel();
        test_long_runs();
        test_random_streams();
        if (fault_count == 0)
            $display("tga_rle_decoder_test: PASS");
        else
            $display("tga_rle_decoder_test: FAIL");
        $finish;
    end

endmodule
